/* hdl/lmsn_pkg.sv */
// ---------------------------------------------------------------------------
// lmsn_pkg
// Shared types and constants of the adaptive multi-tone notch unit: operation
// and register codes, fixed-point widths, memory entry layouts, sequencer
// states and the control word of the shared multiply-accumulate unit.
// ---------------------------------------------------------------------------
package lmsn_pkg;

   // operation codes carried on req_tuser
   localparam logic [1:0] OP_SAMPLE = 2'd0;
   localparam logic [1:0] OP_LOAD   = 2'd1;
   localparam logic [1:0] OP_CLEAR  = 2'd2;

   // configuration register indexes
   localparam logic REG_AMPLITUDE = 1'b0;
   localparam logic REG_TONES     = 1'b1;

   localparam int AMP_W    = 15;
   localparam int TIU_W    = 4;
   localparam int OP_W     = 2;
   localparam int CH_W     = 3;
   localparam int TI_W     = 3;
   localparam int OSC_W    = 32;
   localparam int STEP_W   = 16;
   localparam int WGT_W    = 48;
   localparam int E_W      = 58;   // unclipped error, Q34.24
   localparam int EX_W     = 60;   // error times reference, Q36.24
   localparam int DELTA_W  = 61;
   localparam int LO_W     = 24;   // low part of a split operand
   localparam int MUL_A_W  = 37;
   localparam int MUL_B_W  = 33;
   localparam int PROD_W   = MUL_A_W + MUL_B_W;
   localparam int ACC_W    = 92;
   localparam int ROT_W    = 35;

   localparam logic [AMP_W-1:0] AMP_RESET = 15'd16384;

   typedef struct packed {
      logic [STEP_W-1:0]       step;
      logic signed [OSC_W-1:0] rot_sin;
      logic signed [OSC_W-1:0] rot_cos;
      logic signed [OSC_W-1:0] osc_sin;
      logic signed [OSC_W-1:0] osc_cos;
   } tone_type;

   typedef struct packed {
      logic signed [WGT_W-1:0] w_sin;
      logic signed [WGT_W-1:0] w_cos;
   } weight_type;

   // multiply-accumulate control: hi shifts the product up by LO_W
   typedef struct packed {
      logic en;
      logic clr;
      logic sub;
      logic hi;
   } mac_ctl_type;

   typedef enum logic [5:0] {
      ST_CLEAR,
      ST_IDLE,
      ST_LOAD,
      ST_PRED_RD,
      ST_PC_LO,
      ST_PC_HI,
      ST_PC_WAIT,
      ST_PS_LO,
      ST_PS_HI,
      ST_PS_WAIT,
      ST_PRED_NEXT,
      ST_UPD_RD,
      ST_UC_LO,
      ST_UC_HI,
      ST_UC_WAIT,
      ST_DC_LO,
      ST_DC_HI,
      ST_DC_WAIT,
      ST_US_LO,
      ST_US_HI,
      ST_US_WAIT,
      ST_DS_LO,
      ST_DS_HI,
      ST_DS_WAIT,
      ST_UPD_WR,
      ST_FINISH,
      ST_DONE,
      ST_ROT_RD,
      ST_RA_1,
      ST_RA_2,
      ST_RB_1,
      ST_RB_2,
      ST_ROT_WAIT,
      ST_ROT_WR
   } state_type;

endpackage

/* hdl/lmsn_ram.sv */
// ---------------------------------------------------------------------------
// lmsn_ram
// Generic simple dual-port RAM: one write port, one read port, registered
// read data.
// ---------------------------------------------------------------------------
module lmsn_ram #(
   parameter int WIDTH  = 8,
   parameter int DEPTH  = 16,
   parameter int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
   input  logic              clock,
   input  logic              wr_en,
   input  logic [ADDR_W-1:0] wr_addr,
   input  logic [WIDTH-1:0]  wr_data,
   input  logic [ADDR_W-1:0] rd_addr,
   output logic [WIDTH-1:0]  rd_data
);

   logic [WIDTH-1:0] mem [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

/* hdl/lmsn_mac.sv */
// ---------------------------------------------------------------------------
// lmsn_mac
// Shared signed multiplier with a registered product, followed by a wide
// accumulator. Split operands are combined by adding the high partial
// product shifted up by the low part width.
// ---------------------------------------------------------------------------
module lmsn_mac (
   input  logic                                  clock,
   input  logic                                  reset,
   input  lmsn_pkg::mac_ctl_type                 ctl,
   input  logic signed [lmsn_pkg::MUL_A_W-1:0]   mul_a,
   input  logic signed [lmsn_pkg::MUL_B_W-1:0]   mul_b,
   output logic signed [lmsn_pkg::ACC_W-1:0]     acc
);

   logic signed [lmsn_pkg::PROD_W-1:0] prod_ff;
   logic signed [lmsn_pkg::PROD_W-1:0] prod_in;
   lmsn_pkg::mac_ctl_type              ctl_ff;
   logic signed [lmsn_pkg::ACC_W-1:0]  acc_ff;
   logic signed [lmsn_pkg::ACC_W-1:0]  acc_in;
   logic signed [lmsn_pkg::ACC_W-1:0]  addend;
   logic signed [lmsn_pkg::ACC_W-1:0]  base;

   assign prod_in = mul_a * mul_b;

   always_comb begin
      addend = lmsn_pkg::ACC_W'(prod_ff);
      if (ctl_ff.hi) begin
         addend = addend <<< lmsn_pkg::LO_W;
      end
      base = ctl_ff.clr ? '0 : acc_ff;
      if (!ctl_ff.en) begin
         acc_in = acc_ff;
      end else if (ctl_ff.sub) begin
         acc_in = base - addend;
      end else begin
         acc_in = base + addend;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         ctl_ff <= '0;
      end else begin
         ctl_ff <= ctl;
      end
      prod_ff <= prod_in;
      acc_ff  <= acc_in;
   end

   assign acc = acc_ff;

endmodule

/* hdl/lms_adaptive_multitone_notch_unit.sv */
// ---------------------------------------------------------------------------
// lms_adaptive_multitone_notch_unit
// LMS adaptive canceller of several sinusoidal lines over several channels.
// ---------------------------------------------------------------------------
// One item at a time. A sample on a valid channel with n active tones runs
// a prediction and then a weight update for each of its tones, all through
// one shared 37x33 multiplier that sees each weight, error and product as a
// low and a high partial product, with the weight and tone memories read
// ahead in a read state of their own. A sample flagged last of its time
// step adds an oscillator rotation of all NUM_TONES tones, run while its
// result already waits at the output. A load writes one tone entry, a clear
// of all weights is a zeroing sweep of the weight memory. After reset the
// block sweeps both memories to zero before req_tready rises; configuration
// writes are taken at any time.
// ---------------------------------------------------------------------------
module lms_adaptive_multitone_notch_unit #(
   parameter int NUM_TONES    = 8,
   parameter int NUM_CHANNELS = 8,
   parameter int SAMPLE_BITS  = 24,
   parameter int REQ_W        = ((86 + SAMPLE_BITS + 7) / 8) * 8,
   parameter int RSP_W        = ((SAMPLE_BITS + 7) / 8) * 8
) (
   input  logic                            clock,
   input  logic                            reset,
   input  logic                            req_tvalid,
   output logic                            req_tready,
   // channel, sample, tone_index, tone_cos, tone_sin, tone_step, zero fill
   input  logic [REQ_W-1:0]                req_tdata,
   // operation
   input  logic [lmsn_pkg::OP_W-1:0]       req_tuser,
   input  logic                            req_tlast,
   output logic                            rsp_tvalid,
   input  logic                            rsp_tready,
   // cleaned, zero fill
   output logic [RSP_W-1:0]                rsp_tdata,
   // saturated
   output logic                            rsp_tuser,
   input  logic                            csr_we,
   input  logic                            csr_index,
   input  logic [lmsn_pkg::AMP_W-1:0]      csr_wdata
);

   localparam int WDEPTH = NUM_CHANNELS * NUM_TONES;
   localparam int WA_W   = (WDEPTH > 1) ? $clog2(WDEPTH) : 1;
   localparam int TA_W   = (NUM_TONES > 1) ? $clog2(NUM_TONES) : 1;
   localparam int CNT_W  = $clog2(NUM_TONES + 1);
   localparam int C_W    = lmsn_pkg::E_W - 24;
   localparam logic signed [C_W-1:0] SMAX = C_W'((64'sd1 <<< (SAMPLE_BITS - 1)) - 64'sd1);
   localparam logic signed [C_W-1:0] SMIN = -SMAX - C_W'(1);
   localparam int OFS_SMP  = lmsn_pkg::CH_W;
   localparam int OFS_TI   = OFS_SMP + SAMPLE_BITS;
   localparam int OFS_COS  = OFS_TI + lmsn_pkg::TI_W;
   localparam int OFS_SIN  = OFS_COS + lmsn_pkg::OSC_W;
   localparam int OFS_STEP = OFS_SIN + lmsn_pkg::OSC_W;

   lmsn_pkg::state_type state_ff, state_in;

   // configuration
   logic [lmsn_pkg::AMP_W-1:0] amp_ff, amp_in;
   logic [lmsn_pkg::TIU_W-1:0] tiu_ff, tiu_in;

   // latched request
   logic [lmsn_pkg::TI_W-1:0]         ti_ff, ti_in;
   logic signed [lmsn_pkg::OSC_W-1:0] cos_ff, cos_in;
   logic signed [lmsn_pkg::OSC_W-1:0] sin_ff, sin_in;
   logic [lmsn_pkg::STEP_W-1:0]       step_ff, step_in;

   // sequencer and datapath registers
   logic [CNT_W-1:0]                    t_ff, t_in;
   logic [CNT_W-1:0]                    n_ff, n_in;
   logic [WA_W-1:0]                     base_ff, base_in;
   logic [WA_W:0]                       sweep_ff, sweep_in;
   logic                                clr_tone_ff, clr_tone_in;
   logic                                rot_pend_ff, rot_pend_in;
   logic signed [lmsn_pkg::E_W-1:0]     e_ff, e_in;
   logic signed [lmsn_pkg::EX_W-1:0]    ex_ff, ex_in;
   logic signed [lmsn_pkg::WGT_W-1:0]   wc_new_ff, wc_new_in;
   logic signed [lmsn_pkg::OSC_W-1:0]   oc_new_ff, oc_new_in;
   logic [SAMPLE_BITS-1:0]              res_clean_ff, res_clean_in;
   logic                                res_sat_ff, res_sat_in;
   logic                                rsp_valid_ff, rsp_valid_in;
   logic [SAMPLE_BITS-1:0]              rsp_clean_ff, rsp_clean_in;
   logic                                rsp_sat_ff, rsp_sat_in;

   // combinational
   logic                                req_fire;
   logic                                rsp_free;
   logic [CNT_W-1:0]                    n_act;
   logic                                ch_ok;
   logic                                loop_end;
   logic [WA_W-1:0]                     wgt_addr;
   logic [TA_W-1:0]                     tone_addr;
   lmsn_pkg::tone_type                  tone_rd;
   lmsn_pkg::weight_type                wgt_rd;
   lmsn_pkg::tone_type                  tone_wdata;
   lmsn_pkg::weight_type                wgt_wdata;
   logic                                tone_we, wgt_we;
   logic [TA_W-1:0]                     tone_waddr;
   logic [WA_W-1:0]                     wgt_waddr;
   lmsn_pkg::mac_ctl_type               mac_ctl;
   logic signed [lmsn_pkg::MUL_A_W-1:0] mul_a;
   logic signed [lmsn_pkg::MUL_B_W-1:0] mul_b;
   logic signed [lmsn_pkg::ACC_W-1:0]   acc;
   logic signed [lmsn_pkg::E_W-1:0]     term;
   logic signed [lmsn_pkg::EX_W-1:0]    ex_new;
   logic signed [lmsn_pkg::DELTA_W-1:0] delta;
   logic signed [lmsn_pkg::ROT_W-1:0]   rot_val;
   logic signed [lmsn_pkg::DELTA_W:0]   wsum;
   logic signed [lmsn_pkg::WGT_W-1:0]   w_old;
   logic signed [lmsn_pkg::WGT_W-1:0]   w_sat;
   logic signed [lmsn_pkg::OSC_W-1:0]   osc_sat;
   logic signed [C_W-1:0]               c_val;
   logic [SAMPLE_BITS-1:0]              req_sample;
   logic [lmsn_pkg::CH_W-1:0]           req_ch;

   lmsn_ram #(
      .WIDTH ($bits(lmsn_pkg::weight_type)),
      .DEPTH (WDEPTH),
      .ADDR_W(WA_W)
   ) u_wgt_ram (
      .clock  (clock),
      .wr_en  (wgt_we),
      .wr_addr(wgt_waddr),
      .wr_data(wgt_wdata),
      .rd_addr(wgt_addr),
      .rd_data(wgt_rd)
   );

   lmsn_ram #(
      .WIDTH ($bits(lmsn_pkg::tone_type)),
      .DEPTH (NUM_TONES),
      .ADDR_W(TA_W)
   ) u_tone_ram (
      .clock  (clock),
      .wr_en  (tone_we),
      .wr_addr(tone_waddr),
      .wr_data(tone_wdata),
      .rd_addr(tone_addr),
      .rd_data(tone_rd)
   );

   lmsn_mac u_mac (
      .clock(clock),
      .reset(reset),
      .ctl  (mac_ctl),
      .mul_a(mul_a),
      .mul_b(mul_b),
      .acc  (acc)
   );

   assign req_sample = req_tdata[OFS_SMP +: SAMPLE_BITS];
   assign req_ch     = req_tdata[lmsn_pkg::CH_W-1:0];
   assign req_fire   = req_tvalid && req_tready;
   assign rsp_free   = !rsp_valid_ff || rsp_tready;
   assign n_act      = (32'(tiu_ff) > NUM_TONES) ? CNT_W'(NUM_TONES) : CNT_W'(tiu_ff);
   assign ch_ok      = 32'(req_ch) < NUM_CHANNELS;
   assign loop_end   = (t_ff + CNT_W'(1)) == n_ff;
   assign wgt_addr   = base_ff + WA_W'(t_ff);
   assign tone_addr  = t_ff[TA_W-1:0];

   // fixed-point views of the accumulator
   assign term    = acc[30 +: lmsn_pkg::E_W];
   assign ex_new  = acc[30 +: lmsn_pkg::EX_W];
   assign delta   = acc[15 +: lmsn_pkg::DELTA_W];
   assign rot_val = acc[30 +: lmsn_pkg::ROT_W];
   assign c_val   = e_ff[lmsn_pkg::E_W-1:24];

   // weight update with saturation to 48 bits
   always_comb begin
      w_old = (state_ff == lmsn_pkg::ST_US_LO) ? wgt_rd.w_cos : wgt_rd.w_sin;
      wsum  = (lmsn_pkg::DELTA_W + 1)'(w_old) + (lmsn_pkg::DELTA_W + 1)'(delta);
      if (wsum[lmsn_pkg::DELTA_W:lmsn_pkg::WGT_W-1] == '0 ||
          wsum[lmsn_pkg::DELTA_W:lmsn_pkg::WGT_W-1] == '1) begin
         w_sat = wsum[lmsn_pkg::WGT_W-1:0];
      end else if (wsum[lmsn_pkg::DELTA_W]) begin
         w_sat = {1'b1, {(lmsn_pkg::WGT_W-1){1'b0}}};
      end else begin
         w_sat = {1'b0, {(lmsn_pkg::WGT_W-1){1'b1}}};
      end
   end

   // oscillator saturation to 32 bits
   always_comb begin
      if (rot_val[lmsn_pkg::ROT_W-1:lmsn_pkg::OSC_W-1] == '0 ||
          rot_val[lmsn_pkg::ROT_W-1:lmsn_pkg::OSC_W-1] == '1) begin
         osc_sat = rot_val[lmsn_pkg::OSC_W-1:0];
      end else if (rot_val[lmsn_pkg::ROT_W-1]) begin
         osc_sat = {1'b1, {(lmsn_pkg::OSC_W-1){1'b0}}};
      end else begin
         osc_sat = {1'b0, {(lmsn_pkg::OSC_W-1){1'b1}}};
      end
   end

   // next state
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         lmsn_pkg::ST_CLEAR: begin
            if (sweep_ff == (WA_W + 1)'(WDEPTH - 1)) begin
               state_in = clr_tone_ff ? lmsn_pkg::ST_IDLE : lmsn_pkg::ST_DONE;
            end
         end
         lmsn_pkg::ST_IDLE: begin
            if (req_fire) begin
               priority case (req_tuser)
                  lmsn_pkg::OP_SAMPLE: begin
                     state_in = (ch_ok && n_act != '0) ? lmsn_pkg::ST_PRED_RD
                                                       : lmsn_pkg::ST_FINISH;
                  end
                  lmsn_pkg::OP_LOAD:  state_in = lmsn_pkg::ST_LOAD;
                  lmsn_pkg::OP_CLEAR: state_in = lmsn_pkg::ST_CLEAR;
                  default:            state_in = lmsn_pkg::ST_DONE;
               endcase
            end
         end
         lmsn_pkg::ST_LOAD:      state_in = lmsn_pkg::ST_DONE;
         lmsn_pkg::ST_PRED_RD:   state_in = lmsn_pkg::ST_PC_LO;
         lmsn_pkg::ST_PC_LO:     state_in = lmsn_pkg::ST_PC_HI;
         lmsn_pkg::ST_PC_HI:     state_in = lmsn_pkg::ST_PC_WAIT;
         lmsn_pkg::ST_PC_WAIT:   state_in = lmsn_pkg::ST_PS_LO;
         lmsn_pkg::ST_PS_LO:     state_in = lmsn_pkg::ST_PS_HI;
         lmsn_pkg::ST_PS_HI:     state_in = lmsn_pkg::ST_PS_WAIT;
         lmsn_pkg::ST_PS_WAIT:   state_in = lmsn_pkg::ST_PRED_NEXT;
         lmsn_pkg::ST_PRED_NEXT: begin
            state_in = loop_end ? lmsn_pkg::ST_UPD_RD : lmsn_pkg::ST_PRED_RD;
         end
         lmsn_pkg::ST_UPD_RD:    state_in = lmsn_pkg::ST_UC_LO;
         lmsn_pkg::ST_UC_LO:     state_in = lmsn_pkg::ST_UC_HI;
         lmsn_pkg::ST_UC_HI:     state_in = lmsn_pkg::ST_UC_WAIT;
         lmsn_pkg::ST_UC_WAIT:   state_in = lmsn_pkg::ST_DC_LO;
         lmsn_pkg::ST_DC_LO:     state_in = lmsn_pkg::ST_DC_HI;
         lmsn_pkg::ST_DC_HI:     state_in = lmsn_pkg::ST_DC_WAIT;
         lmsn_pkg::ST_DC_WAIT:   state_in = lmsn_pkg::ST_US_LO;
         lmsn_pkg::ST_US_LO:     state_in = lmsn_pkg::ST_US_HI;
         lmsn_pkg::ST_US_HI:     state_in = lmsn_pkg::ST_US_WAIT;
         lmsn_pkg::ST_US_WAIT:   state_in = lmsn_pkg::ST_DS_LO;
         lmsn_pkg::ST_DS_LO:     state_in = lmsn_pkg::ST_DS_HI;
         lmsn_pkg::ST_DS_HI:     state_in = lmsn_pkg::ST_DS_WAIT;
         lmsn_pkg::ST_DS_WAIT:   state_in = lmsn_pkg::ST_UPD_WR;
         lmsn_pkg::ST_UPD_WR: begin
            state_in = loop_end ? lmsn_pkg::ST_FINISH : lmsn_pkg::ST_UPD_RD;
         end
         lmsn_pkg::ST_FINISH:    state_in = lmsn_pkg::ST_DONE;
         lmsn_pkg::ST_DONE: begin
            if (rsp_free) begin
               state_in = rot_pend_ff ? lmsn_pkg::ST_ROT_RD : lmsn_pkg::ST_IDLE;
            end
         end
         lmsn_pkg::ST_ROT_RD:    state_in = lmsn_pkg::ST_RA_1;
         lmsn_pkg::ST_RA_1:      state_in = lmsn_pkg::ST_RA_2;
         lmsn_pkg::ST_RA_2:      state_in = lmsn_pkg::ST_RB_1;
         lmsn_pkg::ST_RB_1:      state_in = lmsn_pkg::ST_RB_2;
         lmsn_pkg::ST_RB_2:      state_in = lmsn_pkg::ST_ROT_WAIT;
         lmsn_pkg::ST_ROT_WAIT:  state_in = lmsn_pkg::ST_ROT_WR;
         lmsn_pkg::ST_ROT_WR: begin
            if (t_ff == CNT_W'(NUM_TONES - 1)) begin
               state_in = lmsn_pkg::ST_IDLE;
            end else begin
               state_in = lmsn_pkg::ST_ROT_RD;
            end
         end
         default: state_in = lmsn_pkg::ST_IDLE;
      endcase
   end

   // outputs: ready, multiplier operands, accumulator control, memory writes
   always_comb begin
      req_tready = 1'b0;
      mac_ctl    = '0;
      mul_a      = '0;
      mul_b      = '0;
      wgt_we     = 1'b0;
      wgt_waddr  = wgt_addr;
      wgt_wdata  = '0;
      tone_we    = 1'b0;
      tone_waddr = tone_addr;
      tone_wdata = '0;
      unique case (state_ff)
         lmsn_pkg::ST_CLEAR: begin
            wgt_we     = 1'b1;
            wgt_waddr  = sweep_ff[WA_W-1:0];
            tone_we    = clr_tone_ff && (32'(sweep_ff) < NUM_TONES);
            tone_waddr = sweep_ff[TA_W-1:0];
         end
         lmsn_pkg::ST_IDLE: req_tready = 1'b1;
         lmsn_pkg::ST_LOAD: begin
            tone_we            = 32'(ti_ff) < NUM_TONES;
            tone_waddr         = TA_W'(ti_ff);
            tone_wdata.step    = step_ff;
            tone_wdata.rot_sin = sin_ff;
            tone_wdata.rot_cos = cos_ff;
            tone_wdata.osc_sin = '0;
            tone_wdata.osc_cos = lmsn_pkg::OSC_W'({amp_ff, 16'd0});
         end
         lmsn_pkg::ST_PC_LO: begin
            mac_ctl = '{en: 1'b1, clr: 1'b1, sub: 1'b0, hi: 1'b0};
            mul_a   = lmsn_pkg::MUL_A_W'(wgt_rd.w_cos[lmsn_pkg::LO_W-1:0]);
            mul_b   = lmsn_pkg::MUL_B_W'(tone_rd.osc_cos);
         end
         lmsn_pkg::ST_PC_HI: begin
            mac_ctl = '{en: 1'b1, clr: 1'b0, sub: 1'b0, hi: 1'b1};
            mul_a   = lmsn_pkg::MUL_A_W'(
                      $signed(wgt_rd.w_cos[lmsn_pkg::WGT_W-1:lmsn_pkg::LO_W]));
            mul_b   = lmsn_pkg::MUL_B_W'(tone_rd.osc_cos);
         end
         lmsn_pkg::ST_PS_LO: begin
            mac_ctl = '{en: 1'b1, clr: 1'b1, sub: 1'b0, hi: 1'b0};
            mul_a   = lmsn_pkg::MUL_A_W'(wgt_rd.w_sin[lmsn_pkg::LO_W-1:0]);
            mul_b   = lmsn_pkg::MUL_B_W'(tone_rd.osc_sin);
         end
         lmsn_pkg::ST_PS_HI: begin
            mac_ctl = '{en: 1'b1, clr: 1'b0, sub: 1'b0, hi: 1'b1};
            mul_a   = lmsn_pkg::MUL_A_W'(
                      $signed(wgt_rd.w_sin[lmsn_pkg::WGT_W-1:lmsn_pkg::LO_W]));
            mul_b   = lmsn_pkg::MUL_B_W'(tone_rd.osc_sin);
         end
         lmsn_pkg::ST_UC_LO, lmsn_pkg::ST_US_LO: begin
            mac_ctl = '{en: 1'b1, clr: 1'b1, sub: 1'b0, hi: 1'b0};
            mul_a   = lmsn_pkg::MUL_A_W'(e_ff[lmsn_pkg::LO_W-1:0]);
            mul_b   = (state_ff == lmsn_pkg::ST_UC_LO) ?
                      lmsn_pkg::MUL_B_W'(tone_rd.osc_cos) :
                      lmsn_pkg::MUL_B_W'(tone_rd.osc_sin);
         end
         lmsn_pkg::ST_UC_HI, lmsn_pkg::ST_US_HI: begin
            mac_ctl = '{en: 1'b1, clr: 1'b0, sub: 1'b0, hi: 1'b1};
            mul_a   = lmsn_pkg::MUL_A_W'($signed(e_ff[lmsn_pkg::E_W-1:lmsn_pkg::LO_W]));
            mul_b   = (state_ff == lmsn_pkg::ST_UC_HI) ?
                      lmsn_pkg::MUL_B_W'(tone_rd.osc_cos) :
                      lmsn_pkg::MUL_B_W'(tone_rd.osc_sin);
         end
         lmsn_pkg::ST_DC_LO, lmsn_pkg::ST_DS_LO: begin
            mac_ctl = '{en: 1'b1, clr: 1'b1, sub: 1'b0, hi: 1'b0};
            mul_a   = lmsn_pkg::MUL_A_W'(ex_new[lmsn_pkg::LO_W-1:0]);
            mul_b   = lmsn_pkg::MUL_B_W'(tone_rd.step);
         end
         lmsn_pkg::ST_DC_HI, lmsn_pkg::ST_DS_HI: begin
            mac_ctl = '{en: 1'b1, clr: 1'b0, sub: 1'b0, hi: 1'b1};
            mul_a   = lmsn_pkg::MUL_A_W'($signed(ex_ff[lmsn_pkg::EX_W-1:lmsn_pkg::LO_W]));
            mul_b   = lmsn_pkg::MUL_B_W'(tone_rd.step);
         end
         lmsn_pkg::ST_UPD_WR: begin
            wgt_we          = 1'b1;
            wgt_wdata.w_cos = wc_new_ff;
            wgt_wdata.w_sin = w_sat;
         end
         lmsn_pkg::ST_RA_1: begin
            mac_ctl = '{en: 1'b1, clr: 1'b1, sub: 1'b0, hi: 1'b0};
            mul_a   = lmsn_pkg::MUL_A_W'(tone_rd.osc_cos);
            mul_b   = lmsn_pkg::MUL_B_W'(tone_rd.rot_cos);
         end
         lmsn_pkg::ST_RA_2: begin
            mac_ctl = '{en: 1'b1, clr: 1'b0, sub: 1'b1, hi: 1'b0};
            mul_a   = lmsn_pkg::MUL_A_W'(tone_rd.osc_sin);
            mul_b   = lmsn_pkg::MUL_B_W'(tone_rd.rot_sin);
         end
         lmsn_pkg::ST_RB_1: begin
            mac_ctl = '{en: 1'b1, clr: 1'b1, sub: 1'b0, hi: 1'b0};
            mul_a   = lmsn_pkg::MUL_A_W'(tone_rd.osc_cos);
            mul_b   = lmsn_pkg::MUL_B_W'(tone_rd.rot_sin);
         end
         lmsn_pkg::ST_RB_2: begin
            mac_ctl = '{en: 1'b1, clr: 1'b0, sub: 1'b0, hi: 1'b0};
            mul_a   = lmsn_pkg::MUL_A_W'(tone_rd.osc_sin);
            mul_b   = lmsn_pkg::MUL_B_W'(tone_rd.rot_cos);
         end
         lmsn_pkg::ST_ROT_WR: begin
            tone_we            = 1'b1;
            tone_wdata.step    = tone_rd.step;
            tone_wdata.rot_sin = tone_rd.rot_sin;
            tone_wdata.rot_cos = tone_rd.rot_cos;
            tone_wdata.osc_cos = oc_new_ff;
            tone_wdata.osc_sin = osc_sat;
         end
         default: begin
         end
      endcase
   end

   // datapath register next values
   always_comb begin
      amp_in       = amp_ff;
      tiu_in       = tiu_ff;
      ti_in        = ti_ff;
      cos_in       = cos_ff;
      sin_in       = sin_ff;
      step_in      = step_ff;
      t_in         = t_ff;
      n_in         = n_ff;
      base_in      = base_ff;
      sweep_in     = sweep_ff;
      clr_tone_in  = clr_tone_ff;
      rot_pend_in  = rot_pend_ff;
      e_in         = e_ff;
      ex_in        = ex_ff;
      wc_new_in    = wc_new_ff;
      oc_new_in    = oc_new_ff;
      res_clean_in = res_clean_ff;
      res_sat_in   = res_sat_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_tready;
      rsp_clean_in = rsp_clean_ff;
      rsp_sat_in   = rsp_sat_ff;

      if (csr_we) begin
         unique case (csr_index)
            lmsn_pkg::REG_AMPLITUDE: amp_in = csr_wdata;
            lmsn_pkg::REG_TONES:     tiu_in = csr_wdata[lmsn_pkg::TIU_W-1:0];
         endcase
      end

      unique case (state_ff)
         lmsn_pkg::ST_CLEAR: begin
            sweep_in = sweep_ff + (WA_W + 1)'(1);
            if (sweep_ff == (WA_W + 1)'(WDEPTH - 1)) begin
               clr_tone_in = 1'b0;
            end
         end
         lmsn_pkg::ST_IDLE: begin
            if (req_fire) begin
               ti_in        = req_tdata[OFS_TI +: lmsn_pkg::TI_W];
               cos_in       = req_tdata[OFS_COS +: lmsn_pkg::OSC_W];
               sin_in       = req_tdata[OFS_SIN +: lmsn_pkg::OSC_W];
               step_in      = req_tdata[OFS_STEP +: lmsn_pkg::STEP_W];
               n_in         = n_act;
               t_in         = '0;
               sweep_in     = '0;
               base_in      = ch_ok ? WA_W'(32'(req_ch) * NUM_TONES) : '0;
               rot_pend_in  = (req_tuser == lmsn_pkg::OP_SAMPLE) && req_tlast;
               e_in         = lmsn_pkg::E_W'($signed(req_sample)) <<< 24;
               res_clean_in = '0;
               res_sat_in   = 1'b0;
            end
         end
         lmsn_pkg::ST_PS_LO, lmsn_pkg::ST_PRED_NEXT: begin
            e_in = e_ff - term;
            if (state_ff == lmsn_pkg::ST_PRED_NEXT) begin
               t_in = loop_end ? '0 : t_ff + CNT_W'(1);
            end
         end
         lmsn_pkg::ST_DC_LO, lmsn_pkg::ST_DS_LO: ex_in = ex_new;
         lmsn_pkg::ST_US_LO:  wc_new_in = w_sat;
         lmsn_pkg::ST_UPD_WR: t_in = t_ff + CNT_W'(1);
         lmsn_pkg::ST_FINISH: begin
            // clip the error to the sample range
            if (c_val > SMAX) begin
               res_clean_in = SMAX[SAMPLE_BITS-1:0];
               res_sat_in   = 1'b1;
            end else if (c_val < SMIN) begin
               res_clean_in = SMIN[SAMPLE_BITS-1:0];
               res_sat_in   = 1'b1;
            end else begin
               res_clean_in = c_val[SAMPLE_BITS-1:0];
               res_sat_in   = 1'b0;
            end
         end
         lmsn_pkg::ST_DONE: begin
            if (rsp_free) begin
               rsp_valid_in = 1'b1;
               rsp_clean_in = res_clean_ff;
               rsp_sat_in   = res_sat_ff;
               t_in         = '0;
            end
         end
         lmsn_pkg::ST_RB_2:   oc_new_in = osc_sat;
         lmsn_pkg::ST_ROT_WR: t_in = t_ff + CNT_W'(1);
         default: begin
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= lmsn_pkg::ST_CLEAR;
         amp_ff       <= lmsn_pkg::AMP_RESET;
         tiu_ff       <= '0;
         t_ff         <= '0;
         sweep_ff     <= '0;
         clr_tone_ff  <= 1'b1;
         rot_pend_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         amp_ff       <= amp_in;
         tiu_ff       <= tiu_in;
         t_ff         <= t_in;
         sweep_ff     <= sweep_in;
         clr_tone_ff  <= clr_tone_in;
         rot_pend_ff  <= rot_pend_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      ti_ff        <= ti_in;
      cos_ff       <= cos_in;
      sin_ff       <= sin_in;
      step_ff      <= step_in;
      n_ff         <= n_in;
      base_ff      <= base_in;
      e_ff         <= e_in;
      ex_ff        <= ex_in;
      wc_new_ff    <= wc_new_in;
      oc_new_ff    <= oc_new_in;
      res_clean_ff <= res_clean_in;
      res_sat_ff   <= res_sat_in;
      rsp_clean_ff <= rsp_clean_in;
      rsp_sat_ff   <= rsp_sat_in;
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = RSP_W'(rsp_clean_ff);
   assign rsp_tuser  = rsp_sat_ff;

endmodule
